### hdl/tdc_pkg.sv
package tdc_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BOX_W      = 31;
   localparam int unsigned DIFF_W     = 33;
   localparam int unsigned WRAP_STEPS = DIFF_W;
   localparam int unsigned ROOT_STEPS = 32;
   localparam int unsigned NRM_STEPS  = 31;
   localparam int unsigned QUO_STEPS  = 32;

   // Conversion factor in Q16.16: round(5034.11861687 * 2^16).
   localparam logic [28:0] COUPLING_A = 29'd329915998;
   localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

   typedef enum logic [1:0] {
      REG_BOX_X = 2'd0,
      REG_BOX_Y = 2'd1,
      REG_BOX_Z = 2'd2,
      REG_CUT   = 2'd3
   } csr_index_type;

   typedef logic [2:0][WORD_W-1:0] vec3_type;

   typedef struct packed {
      vec3_type a;
      vec3_type b;
   } dip_type;

   typedef struct packed {
      logic [2:0][BOX_W-1:0]  rem;
      logic [2:0][DIFF_W-1:0] mag;
      logic [2:0]             neg;
      dip_type                dip;
   } wrap_type;

   typedef struct packed {
      vec3_type r;
      dip_type  dip;
   } sep_type;

   typedef struct packed {
      logic [2:0][63:0] sq;
      vec3_type         r;
      dip_type          dip;
   } sqr_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] x;
      logic        zero;
      vec3_type    absr;
      logic [2:0]  neg;
      dip_type     dip;
   } root_type;

   typedef struct packed {
      logic [2:0][31:0] rem;
      logic [2:0][30:0] q;
      logic [31:0]      d;
      logic             zero;
      vec3_type         absr;
      logic [2:0]       neg;
      dip_type          dip;
   } norm_type;

   typedef struct packed {
      logic [2:0][63:0] pa;
      logic [2:0][63:0] pb;
      logic [2:0][63:0] gm;
      logic [2:0]       neg;
      logic [31:0]      d;
      logic             zero;
   } prod_type;

   typedef struct packed {
      logic [63:0] sa;
      logic [63:0] sb;
      logic [65:0] g0;
      logic [31:0] d;
      logic        zero;
   } sum_type;

   typedef struct packed {
      logic [33:0] ua;
      logic [33:0] ub;
      logic [65:0] g0;
      logic [63:0] dd;
      logic [31:0] d;
      logic        zero;
   } proj_type;

   typedef struct packed {
      logic [67:0] p;
      logic [65:0] g0;
      logic [63:0] ddl;
      logic [63:0] ddh;
      logic        zero;
   } tpl_type;

   typedef struct packed {
      logic [71:0] g;
      logic [95:0] den;
      logic        zero;
   } geo_type;

   typedef struct packed {
      logic [69:0] mag;
      logic        neg;
      logic [95:0] den;
      logic        zero;
   } mag_type;

   typedef struct packed {
      logic [63:0] pl;
      logic [63:0] ph;
      logic        neg;
      logic [95:0] den;
      logic        zero;
   } amp_type;

   typedef struct packed {
      logic [98:0] num;
      logic        neg;
      logic [95:0] den;
      logic        zero;
   } num_type;

   typedef struct packed {
      logic [95:0] rem;
      logic [31:0] q;
      logic [31:0] low;
      logic        ovf;
      logic        neg;
      logic [95:0] den;
      logic        zero;
   } quo_type;

endpackage

### hdl/tdc_req_if.sv
interface tdc_req_if
   import tdc_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] pos_a_x;
   logic signed [WORD_W-1:0] pos_a_y;
   logic signed [WORD_W-1:0] pos_a_z;
   logic signed [WORD_W-1:0] pos_b_x;
   logic signed [WORD_W-1:0] pos_b_y;
   logic signed [WORD_W-1:0] pos_b_z;
   logic signed [WORD_W-1:0] dip_a_x;
   logic signed [WORD_W-1:0] dip_a_y;
   logic signed [WORD_W-1:0] dip_a_z;
   logic signed [WORD_W-1:0] dip_b_x;
   logic signed [WORD_W-1:0] dip_b_y;
   logic signed [WORD_W-1:0] dip_b_z;

   modport source (
      output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
             dip_a_x, dip_a_y, dip_a_z, dip_b_x, dip_b_y, dip_b_z,
      input  ready
   );
   modport sink (
      input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
             dip_a_x, dip_a_y, dip_a_z, dip_b_x, dip_b_y, dip_b_z,
      output ready
   );
endinterface

### hdl/tdc_rsp_if.sv
interface tdc_rsp_if
   import tdc_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] coupling;
   logic                     was_cut;
   logic                     saturated;

   modport source (output valid, coupling, was_cut, saturated, input ready);
   modport sink (input valid, coupling, was_cut, saturated, output ready);
endinterface

### hdl/tdc_csr_if.sv
interface tdc_csr_if
   import tdc_pkg::*;
;
   logic             valid;
   logic             ready;
   csr_index_type    index;
   logic [BOX_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/transition_dipole_coupling_top.sv
// Channel  Direction  Moves per transfer
// req_ch   in         two positions and two transition dipoles
// rsp_ch   out        coupling, was_cut, saturated
// csr_ch   in         one register write (box_x, box_y, box_z, coupling_cut)
//
// One pair enters every cycle while no result waits on rsp_ch.
// Most of the pipeline depth lies in the bit-serial stages of the wrap remainder (33),
// the square root (32), the direction divider (31) and the final divider (32).
// reset is synchronous and clears the valid bits and the configuration registers; req_ch and
// csr_ch hold ready low while it is asserted.
// When a result waits on rsp_ch, every stage holds and req_ch.ready drops.
module transition_dipole_coupling_top
   import tdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tdc_req_if.sink   req_ch,
   tdc_rsp_if.source rsp_ch,
   tdc_csr_if.sink   csr_ch
);

   function automatic logic [63:0] mul_s32(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] ea;
      logic signed [63:0] eb;
      ea = {{32{a[31]}}, a};
      eb = {{32{b[31]}}, b};
      return 64'(ea * eb);
   endfunction

   function automatic logic [63:0] mul_u32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ea;
      logic [63:0] eb;
      ea = {32'b0, a};
      eb = {32'b0, b};
      return ea * eb;
   endfunction

   function automatic logic [67:0] mul_s34(input logic [33:0] a, input logic [33:0] b);
      logic signed [67:0] ea;
      logic signed [67:0] eb;
      ea = {{34{a[33]}}, a};
      eb = {{34{b[33]}}, b};
      return 68'(ea * eb);
   endfunction

   function automatic logic [63:0] mul_amp(input logic [34:0] a);
      logic [63:0] ea;
      logic [63:0] eb;
      ea = {29'b0, a};
      eb = {35'b0, COUPLING_A};
      return ea * eb;
   endfunction

   function automatic logic [63:0] cneg64(input logic [63:0] v, input logic n);
      return n ? -v : v;
   endfunction

   logic adv;

   // Configuration registers
   logic [BOX_W-1:0] box_ff [3];
   logic [BOX_W-1:0] cut_ff;

   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff[0] <= '0;
         box_ff[1] <= '0;
         box_ff[2] <= '0;
         cut_ff    <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_BOX_X: box_ff[0] <= csr_ch.data;
            REG_BOX_Y: box_ff[1] <= csr_ch.data;
            REG_BOX_Z: box_ff[2] <= csr_ch.data;
            REG_CUT:   cut_ff    <= csr_ch.data;
         endcase
      end
   end

   // Output register and global advance
   logic              out_vld_ff;
   logic [31:0]       coupling_ff;
   logic              was_cut_ff;
   logic              saturated_ff;

   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;

   // Input stage: raw differences split into sign and magnitude
   wrap_type wrap_ff [WRAP_STEPS+1];
   logic     wrap_vld_ff [WRAP_STEPS+1];
   wrap_type wrap_ld_in;
   vec3_type pa;
   vec3_type pb;
   logic [DIFF_W-1:0] diff;

   always_comb begin
      pa = {req_ch.pos_a_z, req_ch.pos_a_y, req_ch.pos_a_x};
      pb = {req_ch.pos_b_z, req_ch.pos_b_y, req_ch.pos_b_x};
      wrap_ld_in.dip.a = {req_ch.dip_a_z, req_ch.dip_a_y, req_ch.dip_a_x};
      wrap_ld_in.dip.b = {req_ch.dip_b_z, req_ch.dip_b_y, req_ch.dip_b_x};
      wrap_ld_in.rem   = '0;
      diff = '0;
      for (int k = 0; k < 3; k++) begin
         diff = {pa[k][31], pa[k]} - {pb[k][31], pb[k]};
         wrap_ld_in.neg[k] = diff[DIFF_W-1];
         wrap_ld_in.mag[k] = diff[DIFF_W-1] ? -diff : diff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) wrap_ff[0] <= wrap_ld_in;
   end

   always_ff @(posedge clock) begin
      if (reset) wrap_vld_ff[0] <= 1'b0;
      else if (adv) wrap_vld_ff[0] <= req_ch.valid;
   end

   // Remainder of the magnitude by the box length, one dividend bit a stage
   for (genvar j = 0; j < WRAP_STEPS; j++) begin : g_wrap
      wrap_type    step_in;
      logic [31:0] t;
      logic [31:0] sub;

      always_comb begin
         step_in = wrap_ff[j];
         t   = '0;
         sub = '0;
         for (int k = 0; k < 3; k++) begin
            t   = {wrap_ff[j].rem[k], wrap_ff[j].mag[k][WRAP_STEPS-1-j]};
            sub = t - {1'b0, box_ff[k]};
            step_in.rem[k] = (t >= {1'b0, box_ff[k]}) ? sub[BOX_W-1:0] : t[BOX_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) wrap_ff[j+1] <= step_in;
      end

      always_ff @(posedge clock) begin
         if (reset) wrap_vld_ff[j+1] <= 1'b0;
         else if (adv) wrap_vld_ff[j+1] <= wrap_vld_ff[j];
      end
   end

   // Minimum image: all four candidates formed at once, one picked; a zero box only clamps.
   sep_type     sep_ff;
   logic        sep_vld_ff;
   sep_type     sep_in;
   wrap_type    wl;
   logic [31:0] m32;
   logic [31:0] bx;
   logic [31:0] twom;
   logic [32:0] nmag;

   always_comb begin
      wl = wrap_ff[WRAP_STEPS];
      sep_in.dip = wl.dip;
      sep_in.r   = '0;
      m32  = '0;
      bx   = '0;
      twom = '0;
      nmag = '0;
      for (int k = 0; k < 3; k++) begin
         m32  = {1'b0, wl.rem[k]};
         bx   = {1'b0, box_ff[k]};
         twom = {wl.rem[k], 1'b0};
         nmag = -wl.mag[k];
         if (box_ff[k] == '0) begin
            if (wl.neg[k]) begin
               sep_in.r[k] = (wl.mag[k] > {1'b0, NEG_LIMIT}) ? NEG_LIMIT : nmag[31:0];
            end else begin
               sep_in.r[k] = (wl.mag[k] > {1'b0, POS_LIMIT}) ? POS_LIMIT : wl.mag[k][31:0];
            end
         end else if (!wl.neg[k] || wl.rem[k] == '0) begin
            sep_in.r[k] = (twom > bx) ? m32 - bx : m32;
         end else begin
            sep_in.r[k] = (twom < bx) ? -m32 : bx - m32;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) sep_ff <= sep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) sep_vld_ff <= 1'b0;
      else if (adv) sep_vld_ff <= wrap_vld_ff[WRAP_STEPS];
   end

   // Squares of the separation components
   sqr_type sqr_ff;
   logic    sqr_vld_ff;
   sqr_type sqr_in;

   always_comb begin
      sqr_in.r   = sep_ff.r;
      sqr_in.dip = sep_ff.dip;
      for (int k = 0; k < 3; k++) begin
         sqr_in.sq[k] = mul_s32(sep_ff.r[k], sep_ff.r[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) sqr_ff <= sqr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) sqr_vld_ff <= 1'b0;
      else if (adv) sqr_vld_ff <= sep_vld_ff;
   end

   // Squared distance and the start of the square root
   root_type root_ff [ROOT_STEPS+1];
   logic     root_vld_ff [ROOT_STEPS+1];
   root_type root_ld_in;

   always_comb begin
      root_ld_in.dip  = sqr_ff.dip;
      root_ld_in.rem  = '0;
      root_ld_in.root = '0;
      root_ld_in.x    = sqr_ff.sq[0] + sqr_ff.sq[1] + sqr_ff.sq[2];
      root_ld_in.zero = (root_ld_in.x == '0);
      for (int k = 0; k < 3; k++) begin
         root_ld_in.neg[k]  = sqr_ff.r[k][31];
         root_ld_in.absr[k] = sqr_ff.r[k][31] ? -sqr_ff.r[k] : sqr_ff.r[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) root_ff[0] <= root_ld_in;
   end

   always_ff @(posedge clock) begin
      if (reset) root_vld_ff[0] <= 1'b0;
      else if (adv) root_vld_ff[0] <= sqr_vld_ff;
   end

   // Integer square root, one result bit a stage
   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      root_type    step_in;
      logic [35:0] t;
      logic [35:0] trial;
      logic [35:0] sub;
      logic        ge;

      always_comb begin
         step_in = root_ff[i];
         t       = {root_ff[i].rem, root_ff[i].x[63-2*i -: 2]};
         trial   = {2'b0, root_ff[i].root, 2'b01};
         sub     = t - trial;
         ge      = (t >= trial);
         step_in.rem  = ge ? sub[33:0] : t[33:0];
         step_in.root = {root_ff[i].root[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) root_ff[i+1] <= step_in;
      end

      always_ff @(posedge clock) begin
         if (reset) root_vld_ff[i+1] <= 1'b0;
         else if (adv) root_vld_ff[i+1] <= root_vld_ff[i];
      end
   end

   // Direction divider: |R| * 2^30 / d. Since |R| <= d, the dividend bits above
   // bit 30 give no quotient bits and are preloaded into the remainder.
   norm_type norm_ff [NRM_STEPS+1];
   logic     norm_vld_ff [NRM_STEPS+1];
   norm_type norm_ld_in;

   always_comb begin
      norm_ld_in.d    = root_ff[ROOT_STEPS].root;
      norm_ld_in.zero = root_ff[ROOT_STEPS].zero;
      norm_ld_in.absr = root_ff[ROOT_STEPS].absr;
      norm_ld_in.neg  = root_ff[ROOT_STEPS].neg;
      norm_ld_in.dip  = root_ff[ROOT_STEPS].dip;
      norm_ld_in.q    = '0;
      for (int k = 0; k < 3; k++) begin
         norm_ld_in.rem[k] = {1'b0, root_ff[ROOT_STEPS].absr[k][31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) norm_ff[0] <= norm_ld_in;
   end

   always_ff @(posedge clock) begin
      if (reset) norm_vld_ff[0] <= 1'b0;
      else if (adv) norm_vld_ff[0] <= root_vld_ff[ROOT_STEPS];
   end

   for (genvar j = 0; j < NRM_STEPS; j++) begin : g_norm
      localparam bit FIRST = (j == 0);
      norm_type    step_in;
      logic [32:0] t;
      logic [32:0] sub;
      logic        ge;

      always_comb begin
         step_in = norm_ff[j];
         t   = '0;
         sub = '0;
         ge  = 1'b0;
         for (int k = 0; k < 3; k++) begin
            t   = {norm_ff[j].rem[k], FIRST ? norm_ff[j].absr[k][0] : 1'b0};
            sub = t - {1'b0, norm_ff[j].d};
            ge  = (t >= {1'b0, norm_ff[j].d});
            step_in.rem[k] = ge ? sub[31:0] : t[31:0];
            step_in.q[k]   = {norm_ff[j].q[k][29:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) norm_ff[j+1] <= step_in;
      end

      always_ff @(posedge clock) begin
         if (reset) norm_vld_ff[j+1] <= 1'b0;
         else if (adv) norm_vld_ff[j+1] <= norm_vld_ff[j];
      end
   end

   // Dipole products with the unsigned direction; the sign is applied in the sum.
   prod_type prod_ff;
   logic     prod_vld_ff;
   prod_type prod_in;
   norm_type nl;

   always_comb begin
      nl = norm_ff[NRM_STEPS];
      prod_in.neg  = nl.neg;
      prod_in.d    = nl.d;
      prod_in.zero = nl.zero;
      for (int k = 0; k < 3; k++) begin
         prod_in.pa[k] = mul_s32(nl.dip.a[k], {1'b0, nl.q[k]});
         prod_in.pb[k] = mul_s32(nl.dip.b[k], {1'b0, nl.q[k]});
         prod_in.gm[k] = mul_s32(nl.dip.a[k], nl.dip.b[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) prod_vld_ff <= 1'b0;
      else if (adv) prod_vld_ff <= norm_vld_ff[NRM_STEPS];
   end

   sum_type sum_ff;
   logic    sum_vld_ff;
   sum_type sum_in;

   always_comb begin
      sum_in.d    = prod_ff.d;
      sum_in.zero = prod_ff.zero;
      sum_in.sa   = cneg64(prod_ff.pa[0], prod_ff.neg[0]) + cneg64(prod_ff.pa[1], prod_ff.neg[1])
                  + cneg64(prod_ff.pa[2], prod_ff.neg[2]);
      sum_in.sb   = cneg64(prod_ff.pb[0], prod_ff.neg[0]) + cneg64(prod_ff.pb[1], prod_ff.neg[1])
                  + cneg64(prod_ff.pb[2], prod_ff.neg[2]);
      sum_in.g0   = {{2{prod_ff.gm[0][63]}}, prod_ff.gm[0]}
                  + {{2{prod_ff.gm[1][63]}}, prod_ff.gm[1]}
                  + {{2{prod_ff.gm[2][63]}}, prod_ff.gm[2]};
   end

   always_ff @(posedge clock) begin
      if (adv) sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) sum_vld_ff <= 1'b0;
      else if (adv) sum_vld_ff <= prod_vld_ff;
   end

   // Projections scaled back to Q16.16, rounded toward zero
   proj_type proj_ff;
   logic     proj_vld_ff;
   proj_type proj_in;

   always_comb begin
      proj_in.g0   = sum_ff.g0;
      proj_in.d    = sum_ff.d;
      proj_in.zero = sum_ff.zero;
      proj_in.dd   = mul_u32(sum_ff.d, sum_ff.d);
      proj_in.ua   = sum_ff.sa[63:30]
                   + {33'b0, sum_ff.sa[63] && (sum_ff.sa[29:0] != '0)};
      proj_in.ub   = sum_ff.sb[63:30]
                   + {33'b0, sum_ff.sb[63] && (sum_ff.sb[29:0] != '0)};
   end

   always_ff @(posedge clock) begin
      if (adv) proj_ff <= proj_in;
   end

   always_ff @(posedge clock) begin
      if (reset) proj_vld_ff <= 1'b0;
      else if (adv) proj_vld_ff <= sum_vld_ff;
   end

   tpl_type tpl_ff;
   logic    tpl_vld_ff;
   tpl_type tpl_in;

   always_comb begin
      tpl_in.p    = mul_s34(proj_ff.ua, proj_ff.ub);
      tpl_in.g0   = proj_ff.g0;
      tpl_in.ddl  = mul_u32(proj_ff.dd[31:0], proj_ff.d);
      tpl_in.ddh  = mul_u32(proj_ff.dd[63:32], proj_ff.d);
      tpl_in.zero = proj_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) tpl_ff <= tpl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) tpl_vld_ff <= 1'b0;
      else if (adv) tpl_vld_ff <= proj_vld_ff;
   end

   // Angular factor G and the cube of the distance
   geo_type     geo_ff;
   logic        geo_vld_ff;
   geo_type     geo_in;
   logic [71:0] p72;

   always_comb begin
      p72         = {{4{tpl_ff.p[67]}}, tpl_ff.p};
      geo_in.g    = {{6{tpl_ff.g0[65]}}, tpl_ff.g0} - (p72 + {p72[70:0], 1'b0});
      geo_in.den  = {32'b0, tpl_ff.ddl} + {tpl_ff.ddh, 32'b0};
      geo_in.zero = tpl_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) geo_ff <= geo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) geo_vld_ff <= 1'b0;
      else if (adv) geo_vld_ff <= tpl_vld_ff;
   end

   mag_type     mag_ff;
   logic        mag_vld_ff;
   mag_type     mag_in;
   logic [71:0] gneg;

   always_comb begin
      gneg        = -geo_ff.g;
      mag_in.neg  = geo_ff.g[71];
      mag_in.mag  = geo_ff.g[71] ? gneg[69:0] : geo_ff.g[69:0];
      mag_in.den  = geo_ff.den;
      mag_in.zero = geo_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) mag_ff <= mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) mag_vld_ff <= 1'b0;
      else if (adv) mag_vld_ff <= geo_vld_ff;
   end

   // |G| * A in two partial products
   amp_type amp_ff;
   logic    amp_vld_ff;
   amp_type amp_in;

   always_comb begin
      amp_in.pl   = mul_amp(mag_ff.mag[34:0]);
      amp_in.ph   = mul_amp(mag_ff.mag[69:35]);
      amp_in.neg  = mag_ff.neg;
      amp_in.den  = mag_ff.den;
      amp_in.zero = mag_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) amp_ff <= amp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) amp_vld_ff <= 1'b0;
      else if (adv) amp_vld_ff <= mag_vld_ff;
   end

   num_type num_ff;
   logic    num_vld_ff;
   num_type num_in;

   always_comb begin
      num_in.num  = {35'b0, amp_ff.pl} + {amp_ff.ph, 35'b0};
      num_in.neg  = amp_ff.neg;
      num_in.den  = amp_ff.den;
      num_in.zero = amp_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) num_ff <= num_in;
   end

   always_ff @(posedge clock) begin
      if (reset) num_vld_ff <= 1'b0;
      else if (adv) num_vld_ff <= amp_vld_ff;
   end

   // Final divider. The dividend is num * 2^16; a quotient of 2^32 or more is
   // caught up front by comparing its upper part against the divisor.
   quo_type quo_ff [QUO_STEPS+1];
   logic    quo_vld_ff [QUO_STEPS+1];
   quo_type quo_ld_in;

   always_comb begin
      quo_ld_in.rem  = {13'b0, num_ff.num[98:16]};
      quo_ld_in.ovf  = ({13'b0, num_ff.num[98:16]} >= num_ff.den);
      quo_ld_in.low  = {num_ff.num[15:0], 16'b0};
      quo_ld_in.q    = '0;
      quo_ld_in.neg  = num_ff.neg;
      quo_ld_in.den  = num_ff.den;
      quo_ld_in.zero = num_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (adv) quo_ff[0] <= quo_ld_in;
   end

   always_ff @(posedge clock) begin
      if (reset) quo_vld_ff[0] <= 1'b0;
      else if (adv) quo_vld_ff[0] <= num_vld_ff;
   end

   for (genvar j = 0; j < QUO_STEPS; j++) begin : g_quo
      quo_type     step_in;
      logic [96:0] t;
      logic [96:0] sub;
      logic        ge;

      always_comb begin
         step_in = quo_ff[j];
         t   = {quo_ff[j].rem, quo_ff[j].low[QUO_STEPS-1-j]};
         sub = t - {1'b0, quo_ff[j].den};
         ge  = (t >= {1'b0, quo_ff[j].den});
         step_in.rem = ge ? sub[95:0] : t[95:0];
         step_in.q   = {quo_ff[j].q[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) quo_ff[j+1] <= step_in;
      end

      always_ff @(posedge clock) begin
         if (reset) quo_vld_ff[j+1] <= 1'b0;
         else if (adv) quo_vld_ff[j+1] <= quo_vld_ff[j];
      end
   end

   // Saturation, cutoff and the zero-distance case
   quo_type     ql;
   logic [31:0] limit;
   logic        sat;
   logic [31:0] coupling_in;
   logic        was_cut_in;
   logic        saturated_in;

   always_comb begin
      ql    = quo_ff[QUO_STEPS];
      limit = ql.neg ? NEG_LIMIT : POS_LIMIT;
      sat   = ql.ovf || (ql.q > limit);
      if (ql.zero) begin
         coupling_in  = POS_LIMIT;
         was_cut_in   = 1'b0;
         saturated_in = 1'b1;
      end else if (sat) begin
         coupling_in  = limit;
         was_cut_in   = 1'b0;
         saturated_in = 1'b1;
      end else if (ql.q < {1'b0, cut_ff}) begin
         coupling_in  = '0;
         was_cut_in   = 1'b1;
         saturated_in = 1'b0;
      end else begin
         coupling_in  = ql.neg ? -ql.q : ql.q;
         was_cut_in   = 1'b0;
         saturated_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coupling_ff  <= coupling_in;
         was_cut_ff   <= was_cut_in;
         saturated_ff <= saturated_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= quo_vld_ff[QUO_STEPS];
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.coupling  = coupling_ff;
   assign rsp_ch.was_cut   = was_cut_ff;
   assign rsp_ch.saturated = saturated_ff;

endmodule

### hdl/tdc_chk.sv
module tdc_chk
   import tdc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] coupling,
   input logic              was_cut,
   input logic              saturated
);

   // A result that is not taken stays on the channel unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(coupling)
         && $stable(was_cut) && $stable(saturated))
      else $error("result changed while stalled");

   // A stalled result stops the whole pipeline, so no new pair is taken.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_flags_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(was_cut && saturated))
      else $error("cut and saturated both set");

   a_cut_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_cut |-> coupling == '0)
      else $error("cut coupling not zero");

   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> (coupling == POS_LIMIT || coupling == NEG_LIMIT))
      else $error("saturated coupling not at a rail");

endmodule

bind transition_dipole_coupling_top tdc_chk u_tdc_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .coupling  (rsp_ch.coupling),
   .was_cut   (rsp_ch.was_cut),
   .saturated (rsp_ch.saturated)
);
